// ===== design/pptd_pkg.sv =====
// Package for the projective 2D point transform: widths, register indexes,
// row reset values, payload structs. No dependencies.
package pptd_pkg;

  localparam int PT_W          = 16;
  localparam int COEF_W        = 16;
  localparam int OUT_FRAC_BITS = 16;
  localparam int PROD_W        = PT_W + COEF_W;
  localparam int SUM_W         = PROD_W + 1;
  localparam int MAG_W         = SUM_W - 1;
  localparam int NUM_W         = MAG_W + OUT_FRAC_BITS;
  localparam int OUT_W         = 32;
  localparam int REG_W         = 3 * COEF_W;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W = 2'd2;

  localparam logic [REG_W-1:0] ROW_X_RESET = 48'h0000_0000_0100;
  localparam logic [REG_W-1:0] ROW_Y_RESET = 48'h0000_0100_0000;
  localparam logic [REG_W-1:0] ROW_W_RESET = 48'h0100_0000_0000;

  typedef struct packed {
    logic signed [COEF_W-1:0] t;
    logic signed [COEF_W-1:0] cy;
    logic signed [COEF_W-1:0] cx;
  } pptd_row_t;

  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
  } pptd_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] proj_x;
    logic signed [OUT_W-1:0] proj_y;
    logic                    w_zero;
    logic                    clipped;
  } pptd_out_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sw;
  } pptd_sums_t;

endpackage

// ===== design/projective_point_transform_2d.sv =====
// Throughput: one transaction per cycle unless out_stall holds a waiting result.
// Stages: multiply, add, abs, the 48-stage restoring divider (one quotient bit
// per stage), then saturate.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, rst high) clears all valid bits and loads the identity
// matrix into the three row registers.
module projective_point_transform_2d import pptd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pptd_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pptd_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  // row registers: t (47:32), cy (31:16), cx (15:0), Q8.8 each
  pptd_row_t row_x, row_y, row_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x <= ROW_X_RESET;
      row_y <= ROW_Y_RESET;
      row_w <= ROW_W_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_X: row_x <= cfg_data;
        REG_ROW_Y: row_y <= cfg_data;
        REG_ROW_W: row_w <= cfg_data;
        default:   ;  // unused index: write dropped
      endcase
    end
  end

  // global advance: every stage moves unless a result waits under stall
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic       sums_valid;
  pptd_sums_t sums;

  // multiply stage then add stage; the coefficient scale cancels in the divide
  pptd_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .row_x      (row_x),
    .row_y      (row_y),
    .row_w      (row_w),
    .sums_valid (sums_valid),
    .sums       (sums)
  );

  // |x|<<16 / |w| and |y|<<16 / |w|, truncated, sign restored, saturated;
  // zero w forces zeros and flags w_zero
  pptd_div u_div (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .sums_valid (sums_valid),
    .sums       (sums),
    .res_valid  (out_valid),
    .res        (out_data)
  );

endmodule

// ===== design/pptd_mac.sv =====
// Row products and sums: two register stages (multiply, then add).
// Depends on pptd_pkg.
module pptd_mac import pptd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       in_valid,
  input  pptd_in_t   in_data,
  input  pptd_row_t  row_x,
  input  pptd_row_t  row_y,
  input  pptd_row_t  row_w,
  output logic       sums_valid,
  output pptd_sums_t sums
);

  logic                     v1;
  logic signed [PROD_W-1:0] xx, xy, yx, yy, wx, wy;
  logic signed [COEF_W-1:0] xt, yt, wt;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      sums_valid <= 1'b0;
    end else if (adv) begin
      v1         <= in_valid;
      sums_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xx <= row_x.cx * in_data.point_x;
      xy <= row_x.cy * in_data.point_y;
      yx <= row_y.cx * in_data.point_x;
      yy <= row_y.cy * in_data.point_y;
      wx <= row_w.cx * in_data.point_x;
      wy <= row_w.cy * in_data.point_y;
      xt <= row_x.t;
      yt <= row_y.t;
      wt <= row_w.t;
      sums.sx <= SUM_W'(xx) + SUM_W'(xy) + SUM_W'(xt);
      sums.sy <= SUM_W'(yx) + SUM_W'(yy) + SUM_W'(yt);
      sums.sw <= SUM_W'(wx) + SUM_W'(wy) + SUM_W'(wt);
    end
  end

endmodule

// ===== design/pptd_div.sv =====
// Sign/magnitude split, two-lane restoring divider (one quotient bit per
// stage), saturation and output register. Depends on pptd_pkg.
module pptd_div import pptd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       sums_valid,
  input  pptd_sums_t sums,
  output logic       res_valid,
  output pptd_out_t  res
);

  logic             v   [NUM_W+1];
  logic [MAG_W-1:0] den [NUM_W+1];
  logic [MAG_W-1:0] rx  [NUM_W+1];
  logic [MAG_W-1:0] ry  [NUM_W+1];
  logic [NUM_W-1:0] qx  [NUM_W+1];
  logic [NUM_W-1:0] qy  [NUM_W+1];
  logic             nx  [NUM_W+1];
  logic             ny  [NUM_W+1];
  logic             wz  [NUM_W+1];

  logic [SUM_W-1:0] abs_x, abs_y, abs_w;

  always_comb begin
    abs_x = sums.sx[SUM_W-1] ? (~sums.sx + SUM_W'(1)) : sums.sx;
    abs_y = sums.sy[SUM_W-1] ? (~sums.sy + SUM_W'(1)) : sums.sy;
    abs_w = sums.sw[SUM_W-1] ? (~sums.sw + SUM_W'(1)) : sums.sw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= sums_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den[0] <= abs_w[MAG_W-1:0];
      rx[0]  <= '0;
      ry[0]  <= '0;
      qx[0]  <= {abs_x[MAG_W-1:0], {OUT_FRAC_BITS{1'b0}}};
      qy[0]  <= {abs_y[MAG_W-1:0], {OUT_FRAC_BITS{1'b0}}};
      nx[0]  <= sums.sx[SUM_W-1] ^ sums.sw[SUM_W-1];
      ny[0]  <= sums.sy[SUM_W-1] ^ sums.sw[SUM_W-1];
      wz[0]  <= (sums.sw == '0);
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [MAG_W:0] tx, ty, dx, dy;
    logic           gx, gy;

    always_comb begin
      tx = {rx[k], qx[k][NUM_W-1]};
      ty = {ry[k], qy[k][NUM_W-1]};
      dx = tx - {1'b0, den[k]};
      dy = ty - {1'b0, den[k]};
      gx = (tx >= {1'b0, den[k]});
      gy = (ty >= {1'b0, den[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den[k+1] <= den[k];
        rx[k+1]  <= gx ? dx[MAG_W-1:0] : tx[MAG_W-1:0];
        ry[k+1]  <= gy ? dy[MAG_W-1:0] : ty[MAG_W-1:0];
        qx[k+1]  <= {qx[k][NUM_W-2:0], gx};
        qy[k+1]  <= {qy[k][NUM_W-2:0], gy};
        nx[k+1]  <= nx[k];
        ny[k+1]  <= ny[k];
        wz[k+1]  <= wz[k];
      end
    end
  end

  // {sat, value}: clamp the magnitude to the signed 32-bit range, then apply sign
  function automatic logic [OUT_W:0] sat_q(input logic [NUM_W-1:0] q, input logic neg);
    logic [NUM_W-1:0] lim;
    logic [OUT_W-1:0] m;
    logic             s;
    lim = neg ? NUM_W'(33'h0_8000_0000) : NUM_W'(33'h0_7FFF_FFFF);
    s   = (q > lim);
    m   = s ? lim[OUT_W-1:0] : q[OUT_W-1:0];
    return {s, neg ? (~m + OUT_W'(1)) : m};
  endfunction

  logic [OUT_W:0] fx, fy;

  always_comb begin
    fx = sat_q(qx[NUM_W], nx[NUM_W]);
    fy = sat_q(qy[NUM_W], ny[NUM_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= v[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.w_zero  <= wz[NUM_W];
      res.proj_x  <= wz[NUM_W] ? '0 : fx[OUT_W-1:0];
      res.proj_y  <= wz[NUM_W] ? '0 : fy[OUT_W-1:0];
      res.clipped <= !wz[NUM_W] && (fx[OUT_W] || fy[OUT_W]);
    end
  end

endmodule

// ===== design/pptd_checker.sv =====
// Port-level checks for projective_point_transform_2d, bound to the top level.
// Depends on pptd_pkg.
module pptd_checker import pptd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input pptd_out_t out_data
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input backpressure only from a stalled result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // zero w gives zero outputs and no clip
  a_wzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.w_zero |->
      out_data.proj_x == '0 && out_data.proj_y == '0 && !out_data.clipped)
    else $error("w_zero result not cleared");

endmodule

bind projective_point_transform_2d pptd_checker u_pptd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
